[rtl/core/lcr_pkg.sv]
// shared constants for the largest connected region core
`timescale 1ns / 1ps

package lcr_pkg;

  // configuration port
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 7;

  localparam logic [CFG_INDEX_W-1:0] REG_GRID_ROWS = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GRID_COLS = 1'd1;

  localparam logic [CFG_DATA_W-1:0] GRID_SIZE_RESET = 7'd64;

  // result width
  localparam int RESULT_W = 13;

  // 8-neighbour walk, row and column steps per direction
  localparam int NUM_DIRS = 8;
  localparam logic signed [1:0] STEP_ROW [NUM_DIRS] = '{
    2'sd1, 2'sd1, 2'sd0, -2'sd1, -2'sd1, -2'sd1, 2'sd0, 2'sd1
  };
  localparam logic signed [1:0] STEP_COL [NUM_DIRS] = '{
    2'sd0, 2'sd1, 2'sd1, 2'sd1, 2'sd0, -2'sd1, -2'sd1, -2'sd1
  };

  // cell memory word: visited flag over filled flag
  localparam logic [1:0] CELL_OPEN_FILLED = 2'b01;
  localparam logic [1:0] CELL_SEEN_FILLED = 2'b11;

endpackage

[rtl/core/lcr_in_if.sv]
// input channel: one grid cell per item
`timescale 1ns / 1ps

interface lcr_in_if;
  logic valid;
  logic ready;
  logic cell_filled;
  logic last_cell;

  modport source (output valid, output cell_filled, output last_cell, input ready);
  modport sink   (input valid, input cell_filled, input last_cell, output ready);
endinterface

[rtl/core/lcr_out_if.sv]
// output channel: one region size per item
`timescale 1ns / 1ps

interface lcr_out_if;
  import lcr_pkg::*;

  logic                valid;
  logic                ready;
  logic [RESULT_W-1:0] largest_region;

  modport source (output valid, output largest_region, input ready);
  modport sink   (input valid, input largest_region, output ready);
endinterface

[rtl/core/largest_connected_region_size_core.sv]
// Largest 8-connected filled region of a binary grid.
// Cells arrive one item per cycle while the core is loading, in row-major
// order, and land in a cell memory (filled and visited flag per cell). The
// item marked last starts the fill: a clearing pass resets the visited
// flags of the rows*cols cells in use (no item accepted meanwhile), then a
// scan visits every position and each new region runs a breadth-first
// fill through a cell queue memory. Every cell taken from the queue is
// popped, then its eight neighbours are probed one at a time through the
// single read port of the cell memory, with a final check step when the
// last neighbour probed lies inside the grid; this sets the pace of the
// fill. One result item, the largest region size, follows
// the last cell; the next grid is taken once that item has been delivered.
// grid_rows and grid_cols above MAX_ROWS/MAX_COLS saturate to the limit.
`timescale 1ns / 1ps

module largest_connected_region_size_core #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [lcr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [lcr_pkg::CFG_DATA_W-1:0]  cfg_data,
  lcr_in_if.sink                         grid,
  lcr_out_if.source                      answer
);
  import lcr_pkg::*;

  localparam int CAP = MAX_ROWS * MAX_COLS;
  localparam int AW  = (CAP > 1) ? $clog2(CAP) : 1;
  localparam int CW  = $clog2(CAP + 1);
  localparam int RIW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CIW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RCW = $clog2(MAX_ROWS + 1);
  localparam int CCW = $clog2(MAX_COLS + 1);
  localparam int QW  = RIW + CIW + AW;

  typedef enum logic [3:0] {
    S_LOAD,
    S_CLEAR,
    S_SCAN,
    S_SCAN_CHK,
    S_POP,
    S_POP_WAIT,
    S_NBR,
    S_DONE,
    S_OUT
  } state_t;

  state_t state;

  // configuration registers
  logic [CFG_DATA_W-1:0] grid_rows;
  logic [CFG_DATA_W-1:0] grid_cols;

  // run registers
  logic [CW-1:0]       load_pos;
  logic [RCW-1:0]      rows_lim;
  logic [CCW-1:0]      cols_lim;
  logic [CW-1:0]       total;
  logic [CW-1:0]       clr_rd;
  logic [AW-1:0]       clr_wa;
  logic                clr_pend;
  logic [CW-1:0]       start;
  logic [RIW-1:0]      sr;
  logic [CIW-1:0]      sc;
  logic [CW-1:0]       head;
  logic [CW-1:0]       tail;
  logic [CW-1:0]       count;
  logic [CW-1:0]       best;
  logic [RIW-1:0]      cur_r;
  logic [CIW-1:0]      cur_c;
  logic [AW-1:0]       cur_pos;
  logic [3:0]          dir;
  logic                pend;
  logic [RIW-1:0]      p_r;
  logic [CIW-1:0]      p_c;
  logic [AW-1:0]       p_pos;
  logic                out_valid;
  logic [RESULT_W-1:0] result;

  // saturated grid size
  logic [RCW-1:0] rows_sat;
  logic [CCW-1:0] cols_sat;

  // memory ports
  logic          cm_we;
  logic [AW-1:0] cm_waddr;
  logic [1:0]    cm_wdata;
  logic [AW-1:0] cm_raddr;
  logic [1:0]    cm_rdata;
  logic          q_we;
  logic [AW-1:0] q_waddr;
  logic [QW-1:0] q_wdata;
  logic [AW-1:0] q_raddr;
  logic [QW-1:0] q_rdata;

  // neighbour under probe
  logic signed [1:0] dr;
  logic signed [1:0] dc;
  logic              nb_ok;
  logic [RIW-1:0]    nb_r;
  logic [CIW-1:0]    nb_c;
  logic [AW-1:0]     nb_pos;
  logic [AW-1:0]     cols_a;

  logic accept_in;
  logic nb_new;
  logic last_col;

  assign accept_in = grid.valid && grid.ready;
  assign nb_new    = pend && (cm_rdata == CELL_OPEN_FILLED);
  assign last_col  = (CCW'(sc) + CCW'(1)) == cols_lim;

  assign grid.ready            = (state == S_LOAD);
  assign answer.valid          = out_valid;
  assign answer.largest_region = result;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows <= GRID_SIZE_RESET;
      grid_cols <= GRID_SIZE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GRID_ROWS: grid_rows <= cfg_data;
        REG_GRID_COLS: grid_cols <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp size to the memory shape
  always_comb begin
    if (int'(grid_rows) > MAX_ROWS) rows_sat = RCW'(MAX_ROWS);
    else rows_sat = RCW'(grid_rows);
    if (int'(grid_cols) > MAX_COLS) cols_sat = CCW'(MAX_COLS);
    else cols_sat = CCW'(grid_cols);
  end

  // neighbour position and bounds for the current direction
  always_comb begin
    logic row_ok;
    logic col_ok;
    dr     = STEP_ROW[dir[2:0]];
    dc     = STEP_COL[dir[2:0]];
    cols_a = AW'(cols_lim);
    row_ok = (dr == 2'sd0) ||
             ((dr == -2'sd1) && (cur_r != '0)) ||
             ((dr == 2'sd1) && ((RCW'(cur_r) + RCW'(1)) < rows_lim));
    col_ok = (dc == 2'sd0) ||
             ((dc == -2'sd1) && (cur_c != '0)) ||
             ((dc == 2'sd1) && ((CCW'(cur_c) + CCW'(1)) < cols_lim));
    nb_ok  = row_ok && col_ok;
    nb_r   = cur_r;
    nb_c   = cur_c;
    nb_pos = cur_pos;
    if (dr == 2'sd1) begin
      nb_r   = cur_r + RIW'(1);
      nb_pos = nb_pos + cols_a;
    end else if (dr == -2'sd1) begin
      nb_r   = cur_r - RIW'(1);
      nb_pos = nb_pos - cols_a;
    end
    if (dc == 2'sd1) begin
      nb_c   = cur_c + CIW'(1);
      nb_pos = nb_pos + AW'(1);
    end else if (dc == -2'sd1) begin
      nb_c   = cur_c - CIW'(1);
      nb_pos = nb_pos - AW'(1);
    end
  end

  // memory port steering
  always_comb begin
    cm_we    = 1'b0;
    cm_waddr = '0;
    cm_wdata = '0;
    cm_raddr = '0;
    q_we     = 1'b0;
    q_waddr  = '0;
    q_wdata  = '0;
    q_raddr  = head[AW-1:0];
    unique case (state)
      S_LOAD: begin
        if (accept_in && (load_pos < CW'(CAP))) begin
          cm_we    = 1'b1;
          cm_waddr = load_pos[AW-1:0];
          cm_wdata = {1'b0, grid.cell_filled};
        end
      end
      S_CLEAR: begin
        cm_raddr = clr_rd[AW-1:0];
        if (clr_pend) begin
          cm_we    = 1'b1;
          cm_waddr = clr_wa;
          cm_wdata = {1'b0, cm_rdata[0]};
        end
      end
      S_SCAN: begin
        cm_raddr = start[AW-1:0];
      end
      S_SCAN_CHK: begin
        if (cm_rdata == CELL_OPEN_FILLED) begin
          cm_we    = 1'b1;
          cm_waddr = start[AW-1:0];
          cm_wdata = CELL_SEEN_FILLED;
          q_we     = 1'b1;
          q_waddr  = '0;
          q_wdata  = {sr, sc, start[AW-1:0]};
        end
      end
      S_NBR: begin
        cm_raddr = nb_pos;
        if (nb_new) begin
          cm_we    = 1'b1;
          cm_waddr = p_pos;
          cm_wdata = CELL_SEEN_FILLED;
          q_we     = 1'b1;
          q_waddr  = tail[AW-1:0];
          q_wdata  = {p_r, p_c, p_pos};
        end
      end
      S_POP, S_POP_WAIT, S_DONE, S_OUT: ;
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      load_pos  <= '0;
      clr_pend  <= 1'b0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
      best      <= '0;
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      dir       <= '0;
    end else begin
      unique case (state)
        // store cells, last item starts the fill
        S_LOAD: begin
          if (accept_in) begin
            if (load_pos < CW'(CAP)) begin
              load_pos <= load_pos + CW'(1);
            end
            if (grid.last_cell) begin
              load_pos <= '0;
              rows_lim <= rows_sat;
              cols_lim <= cols_sat;
              total    <= CW'(rows_sat) * CW'(cols_sat);
              clr_rd   <= '0;
              clr_pend <= 1'b0;
              best     <= '0;
              state    <= S_CLEAR;
            end
          end
        end
        // read-modify-write pass dropping visited flags
        S_CLEAR: begin
          if (clr_rd < total) begin
            clr_wa   <= clr_rd[AW-1:0];
            clr_pend <= 1'b1;
            clr_rd   <= clr_rd + CW'(1);
          end else begin
            clr_pend <= 1'b0;
            if (!clr_pend) begin
              start <= '0;
              sr    <= '0;
              sc    <= '0;
              state <= S_SCAN;
            end
          end
        end
        // look for an unvisited filled cell
        S_SCAN: begin
          if (start == total) begin
            out_valid <= 1'b1;
            result    <= RESULT_W'(best);
            state     <= S_OUT;
          end else begin
            state <= S_SCAN_CHK;
          end
        end
        S_SCAN_CHK: begin
          if (cm_rdata == CELL_OPEN_FILLED) begin
            head  <= '0;
            tail  <= CW'(1);
            count <= CW'(1);
            state <= S_POP;
          end else begin
            start <= start + CW'(1);
            if (last_col) begin
              sc <= '0;
              sr <= sr + RIW'(1);
            end else begin
              sc <= sc + CIW'(1);
            end
            state <= S_SCAN;
          end
        end
        // take the next cell of the region
        S_POP: begin
          if (head < tail) begin
            head  <= head + CW'(1);
            state <= S_POP_WAIT;
          end else begin
            state <= S_DONE;
          end
        end
        S_POP_WAIT: begin
          {cur_r, cur_c, cur_pos} <= q_rdata;
          dir   <= '0;
          pend  <= 1'b0;
          state <= S_NBR;
        end
        // probe one neighbour per cycle, check the one read in the previous cycle
        S_NBR: begin
          if (!dir[3]) begin
            dir   <= dir + 4'd1;
            pend  <= nb_ok;
            p_r   <= nb_r;
            p_c   <= nb_c;
            p_pos <= nb_pos;
          end else begin
            pend <= 1'b0;
          end
          if (nb_new) begin
            tail  <= tail + CW'(1);
            count <= count + CW'(1);
          end
          if (dir[3] && !pend) begin
            state <= S_POP;
          end
        end
        // region finished, keep the best and move on
        S_DONE: begin
          if (count > best) begin
            best <= count;
          end
          start <= start + CW'(1);
          if (last_col) begin
            sc <= '0;
            sr <= sr + RIW'(1);
          end else begin
            sc <= sc + CIW'(1);
          end
          state <= S_SCAN;
        end
        // hold the result item until taken
        S_OUT: begin
          if (answer.ready) begin
            out_valid <= 1'b0;
            state     <= S_LOAD;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  // cell flags: visited over filled
  lcr_ram #(
    .WIDTH(2),
    .DEPTH(CAP),
    .AW   (AW)
  ) u_cell_ram (
    .clk  (clk),
    .we   (cm_we),
    .waddr(cm_waddr),
    .wdata(cm_wdata),
    .raddr(cm_raddr),
    .rdata(cm_rdata)
  );

  // fill queue: row, column and position of each pending cell
  lcr_ram #(
    .WIDTH(QW),
    .DEPTH(CAP),
    .AW   (AW)
  ) u_queue_ram (
    .clk  (clk),
    .we   (q_we),
    .waddr(q_waddr),
    .wdata(q_wdata),
    .raddr(q_raddr),
    .rdata(q_rdata)
  );

endmodule

[rtl/core/lcr_ram.sv]
// generic simple dual port ram with registered read
`timescale 1ns / 1ps

module lcr_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
